/* hdl/nfb_pkg.sv */
// Shared types, constants and offset-table builders for the nearest-first tile block.
`timescale 1ns / 1ps
package nfb_pkg;

   localparam int DefaultRadius  = 2;
   localparam int DefaultMaxZoom = 20;
   localparam int MaxRadius      = 3;
   localparam int MaxSide        = 2 * MaxRadius + 1;
   localparam int MaxCount       = MaxSide * MaxSide;
   localparam int ZoomW          = 5;
   localparam int CoordW         = 20;
   localparam int OffW           = 3;
   localparam int QueueDepth     = 2;

   typedef struct packed {
      logic signed [OffW-1:0] dx;
      logic signed [OffW-1:0] dy;
   } offset_type;

   typedef offset_type [MaxCount-1:0] order_table_type;
   typedef logic [MaxCount-1:0][MaxSide-1:0] later_table_type;

   // One classified base tile waiting for the walk.
   typedef struct packed {
      logic [ZoomW-1:0]   zoom;
      logic [CoordW-1:0]  x;
      logic [CoordW-1:0]  y;
      logic [MaxSide-1:0] row_ok;
   } base_entry_type;

   // Offsets in rising squared distance, scan order (dx outer, dy inner) on ties.
   function automatic order_table_type build_order(int radius);
      order_table_type tab;
      int              k;
      tab = '0;
      k   = 0;
      for (int d = 0; d <= 2 * radius * radius; d++) begin
         for (int dx = -radius; dx <= radius; dx++) begin
            for (int dy = -radius; dy <= radius; dy++) begin
               if (dx * dx + dy * dy == d) begin
                  tab[k].dx = OffW'(dx);
                  tab[k].dy = OffW'(dy);
                  k++;
               end
            end
         end
      end
      return tab;
   endfunction

   // For each step, the set of row offsets that still occur at later steps.
   function automatic later_table_type build_later(int radius);
      later_table_type tab;
      order_table_type ord;
      offset_type      o;
      int              count;
      tab   = '0;
      ord   = build_order(radius);
      count = (2 * radius + 1) * (2 * radius + 1);
      for (int k = 0; k < count; k++) begin
         for (int j = k + 1; j < count; j++) begin
            o = ord[j];
            tab[k][int'(o.dy) + radius] = 1'b1;
         end
      end
      return tab;
   endfunction

endpackage

/* hdl/nfb_front.sv */
// Front end: classify an incoming base tile and work out which rows of its block are in the grid.
`timescale 1ns / 1ps
module nfb_front import nfb_pkg::*; #(
   parameter int BLOCK_RADIUS = DefaultRadius,
   parameter int MAX_ZOOM     = DefaultMaxZoom
) (
   input  logic              base_valid,
   input  logic [ZoomW-1:0]  base_zoom,
   input  logic [CoordW-1:0] base_x,
   input  logic [CoordW-1:0] base_y,
   output logic              keep,
   output base_entry_type    entry
);

   localparam int Side = 2 * BLOCK_RADIUS + 1;

   logic [MaxSide-1:0]  row_ok;
   logic signed [21:0]  y_sum [Side];

   always_comb begin
      row_ok = '0;
      for (int i = 0; i < Side; i++) begin
         y_sum[i]  = $signed({2'b00, base_y}) + 22'(i - BLOCK_RADIUS);
         // row is inside when non-negative and below 2^zoom
         row_ok[i] = !y_sum[i][21] && ((y_sum[i][20:0] >> base_zoom) == 21'd0);
      end
   end

   assign keep = base_valid && (int'(base_zoom) <= MAX_ZOOM) && (|row_ok);

   assign entry.zoom   = base_zoom;
   assign entry.x      = base_x;
   assign entry.y      = base_y;
   assign entry.row_ok = row_ok;

endmodule

/* hdl/nfb_queue.sv */
// Short queue of classified base tiles between the front end and the walk.
`timescale 1ns / 1ps
module nfb_queue import nfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  base_entry_type push_data,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output base_entry_type pop_data
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   base_entry_type slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/nfb_walk.sv */
// Back end: step through the nearest-first offset table and emit tiles of one base.
`timescale 1ns / 1ps
module nfb_walk import nfb_pkg::*; #(
   parameter int BLOCK_RADIUS = DefaultRadius
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  base_entry_type    q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ZoomW-1:0]  rsp_tile_zoom,
   output logic [CoordW-1:0] rsp_tile_x,
   output logic [CoordW-1:0] rsp_tile_y,
   output logic              rsp_last_tile
);

   localparam int Side  = 2 * BLOCK_RADIUS + 1;
   localparam int Count = Side * Side;
   localparam int IdxW  = $clog2(Count);
   localparam int RowW  = $clog2(Side);
   localparam order_table_type OrderAll = build_order(BLOCK_RADIUS);
   localparam later_table_type LaterAll = build_later(BLOCK_RADIUS);

   offset_type      order_tab [Count];
   logic [Side-1:0] later_tab [Count];

   for (genvar k = 0; k < Count; k++) begin : g_tab
      assign order_tab[k] = OrderAll[k];
      assign later_tab[k] = LaterAll[k][Side-1:0];
   end

   logic            busy_ff, busy_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   base_entry_type  cur_ff;
   logic            out_valid_ff, out_valid_in;
   logic [ZoomW-1:0]  zoom_ff;
   logic [CoordW-1:0] x_ff, x_in;
   logic [CoordW-1:0] y_ff, y_in;
   logic              last_ff, last_in;

   offset_type      off;
   logic [RowW-1:0] row_sel;
   logic [Side-1:0] rows;
   logic            ok;
   logic            out_free;
   logic            step;
   logic            finish;
   logic            load;
   logic [CoordW-1:0] x_mask;

   always_comb begin
      off      = order_tab[idx_ff];
      rows     = cur_ff.row_ok[Side-1:0];
      row_sel  = RowW'(int'(off.dy) + BLOCK_RADIUS);
      ok       = rows[row_sel];
      out_free = !out_valid_ff || !rsp_stall;
      step     = busy_ff && (!ok || out_free);
      finish   = step && (idx_ff == IdxW'(Count - 1));
      load     = q_not_empty && (!busy_ff || finish);

      // low zoom bits of the column; shift past the width leaves all ones
      x_mask  = ~({CoordW{1'b1}} << cur_ff.zoom);
      x_in    = (cur_ff.x + CoordW'(off.dx)) & x_mask;
      y_in    = cur_ff.y + CoordW'(off.dy);
      last_in = ~|(later_tab[idx_ff] & rows);

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (step) begin
         idx_in = idx_ff + 1'b1;
      end

      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = busy_ff && ok;
      end
   end

   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_data;
      end
      if (out_free && busy_ff && ok) begin
         zoom_ff <= cur_ff.zoom;
         x_ff    <= x_in;
         y_ff    <= y_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_tile_zoom = zoom_ff;
   assign rsp_tile_x    = x_ff;
   assign rsp_tile_y    = y_ff;
   assign rsp_last_tile = last_ff;

endmodule

/* hdl/nearest_first_tile_block.sv */
// Top level of the nearest-first tile block: front end, base queue and walk.
// Usage:
//   The req_ channel carries one base map tile per request (valid flag, zoom,
//   column, row). For each request the block emits, on the rsp_ channel, the
//   tiles of the square of side 2*BLOCK_RADIUS+1 around the base, nearest
//   first by squared distance, ties in column-then-row scan order. Columns
//   wrap modulo 2^zoom, rows outside the grid are skipped, and the final tile
//   of a base carries rsp_last_tile. A base marked invalid, with zoom above
//   MAX_ZOOM or with no row inside the grid produces no tiles.
//   With the walk idle, a taken request is written into the queue, popped
//   into the walk, and its first tile is registered in the output register;
//   each skipped table entry before that tile delays it further. A queued
//   base waits for the walk in front of it to end.
//   A base that yields tiles is walked through all (2*BLOCK_RADIUS+1)^2
//   entries of the offset table (25 at the default radius), which the walk
//   sequencer steps once a cycle unless rsp_stall holds back a tile to emit;
//   skipped rows still take their step. Dropped requests are taken once a cycle while the queue is not full.
//   A two-entry queue sits between the front end and the walk, so requests
//   keep being taken while a base is walked; req_stall rises only when the
//   queue is full.
//   rsp_stall holds the output register and freezes the walk at the next tile
//   to emit. Reset empties the queue and drops any walk and pending tile.
`timescale 1ns / 1ps
module nearest_first_tile_block import nfb_pkg::*; #(
   parameter int BLOCK_RADIUS = DefaultRadius,
   parameter int MAX_ZOOM     = DefaultMaxZoom
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_base_valid,
   input  logic [ZoomW-1:0]  req_base_zoom,
   input  logic [CoordW-1:0] req_base_x,
   input  logic [CoordW-1:0] req_base_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ZoomW-1:0]  rsp_tile_zoom,
   output logic [CoordW-1:0] rsp_tile_x,
   output logic [CoordW-1:0] rsp_tile_y,
   output logic              rsp_last_tile
);

   logic           keep;
   base_entry_type front_entry;
   logic           q_full;
   logic           q_push;
   logic           q_pop;
   logic           q_not_empty;
   base_entry_type q_data;

   // Classify the request as it arrives.
   nfb_front #(
      .BLOCK_RADIUS (BLOCK_RADIUS),
      .MAX_ZOOM     (MAX_ZOOM)
   ) u_front (
      .base_valid (req_base_valid),
      .base_zoom  (req_base_zoom),
      .base_x     (req_base_x),
      .base_y     (req_base_y),
      .keep       (keep),
      .entry      (front_entry)
   );

   // Hold off requests only while the queue is full; drop bases with no tiles.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && keep;

   nfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   // Walk the offset table for the base at the head of the queue.
   nfb_walk #(
      .BLOCK_RADIUS (BLOCK_RADIUS)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tile_zoom (rsp_tile_zoom),
      .rsp_tile_x    (rsp_tile_x),
      .rsp_tile_y    (rsp_tile_y),
      .rsp_last_tile (rsp_last_tile)
   );

endmodule

/* hdl/nfb_checker.sv */
// Port-level checker for the nearest-first tile block, bound to the top level.
`timescale 1ns / 1ps
module nfb_checker import nfb_pkg::*; #(
   parameter int MAX_ZOOM = DefaultMaxZoom
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [ZoomW-1:0]  rsp_tile_zoom,
   input logic [CoordW-1:0] rsp_tile_x,
   input logic [CoordW-1:0] rsp_tile_y,
   input logic              rsp_last_tile
);

   // A stalled tile holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tile_zoom) &&
         $stable(rsp_tile_x) && $stable(rsp_tile_y) && $stable(rsp_last_tile))
      else $error("stalled tile changed");

   // Reset drops any pending tile.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("tile pending after reset");

   // Emitted zoom never exceeds the supported maximum.
   a_zoom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_tile_zoom) <= MAX_ZOOM)
      else $error("tile zoom out of range");

   // Emitted tile lies inside the 2^zoom grid on both axes.
   a_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_tile_y >> rsp_tile_zoom) == '0) &&
         ((rsp_tile_x >> rsp_tile_zoom) == '0))
      else $error("tile outside grid");

endmodule

bind nearest_first_tile_block nfb_checker #(
   .MAX_ZOOM (MAX_ZOOM)
) u_nfb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_tile_zoom (rsp_tile_zoom),
   .rsp_tile_x    (rsp_tile_x),
   .rsp_tile_y    (rsp_tile_y),
   .rsp_last_tile (rsp_last_tile)
);

/* test/nearest_first_tile_block_test.sv */
// Self-checking testbench for the nearest-first tile block.
`timescale 1ns / 1ps
module nearest_first_tile_block_test;
   import nfb_pkg::*;

   localparam int RADIUS      = DefaultRadius;
   localparam int ZOOM_LIMIT  = DefaultMaxZoom;
   localparam int N_DIRECTED  = 22;
   localparam int N_RANDOM    = 320;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN       = 200;
   // Slowest correct run: about 345 bases x 25 tiles, each tile held for up to
   // the longest receiver stall, plus sender gaps; take it about three times over.
   localparam int CYCLE_LIMIT = 2_000_000;

   // One tile as it leaves the block.
   typedef struct {
      logic [ZoomW-1:0]  zoom;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic              last;
   } map_tile_t;

   // One row of the directed table. Where typed is set, the expected result is
   // written into the row: either no tile, or a single tile at (tx, ty).
   typedef struct {
      bit                ok;
      logic [ZoomW-1:0]  zoom;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      bit                typed;
      bit                one_tile;
      logic [CoordW-1:0] tx;
      logic [CoordW-1:0] ty;
   } stim_row_t;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic              req_base_valid = 1'b0;
   logic [ZoomW-1:0]  req_base_zoom  = '0;
   logic [CoordW-1:0] req_base_x     = '0;
   logic [CoordW-1:0] req_base_y     = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [ZoomW-1:0]  rsp_tile_zoom;
   logic [CoordW-1:0] rsp_tile_x;
   logic [CoordW-1:0] rsp_tile_y;
   logic              rsp_last_tile;

   // Typed expectation travelling alongside the request payload.
   logic              row_typed    = 1'b0;
   logic              row_one_tile = 1'b0;
   logic [CoordW-1:0] row_tx       = '0;
   logic [CoordW-1:0] row_ty       = '0;

   map_tile_t pending_tiles[$];
   int        fault_count    = 0;
   int        tiles_checked  = 0;
   int        requests_taken = 0;
   int        empty_requests = 0;
   int        cycle_count    = 0;
   bit        choke_req      = 1'b0;
   bit        choke_done     = 1'b0;

   stim_row_t directed_rows [0:N_DIRECTED-1] = '{
      // invalid base, then invalid with every field at its top value
      '{1'b0, 5'd5,  20'd3,      20'd3,      1'b1, 1'b0, 20'd0, 20'd0},
      '{1'b0, 5'd31, 20'hFFFFF,  20'hFFFFF,  1'b1, 1'b0, 20'd0, 20'd0},
      // zoom above the limit: dropped
      '{1'b1, 5'd31, 20'd5,      20'd5,      1'b1, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd21, 20'd0,      20'd0,      1'b1, 1'b0, 20'd0, 20'd0},
      // zoom zero: one-tile grid, every column folds to 0, only row 0 survives,
      // so tile (0, 0) comes out once per column of the block
      '{1'b1, 5'd0,  20'd0,      20'd0,      1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd0,  20'hFFFFF,  20'd0,      1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd0,  20'h12345,  20'd1,      1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd0,  20'd0,      20'd2,      1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd0,  20'd0,      20'd3,      1'b1, 1'b0, 20'd0, 20'd0},
      // grid corners at full zoom: wrap on both sides of the column range
      '{1'b1, 5'd20, 20'hFFFFF,  20'hFFFFF,  1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd20, 20'd0,      20'd0,      1'b0, 1'b0, 20'd0, 20'd0},
      // small grids: the block covers the whole grid and more at zooms 1 and 2, and wraps at the column edge at zoom 5
      '{1'b1, 5'd1,  20'd1,      20'd1,      1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd2,  20'd3,      20'd2,      1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd5,  20'd31,     20'd16,     1'b0, 1'b0, 20'd0, 20'd0},
      // column outside the grid, row just past the bottom edge
      '{1'b1, 5'd5,  20'd100,    20'd30,     1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd5,  20'd7,      20'd33,     1'b0, 1'b0, 20'd0, 20'd0},
      // base row too far outside: no row of the block lands in the grid
      '{1'b1, 5'd5,  20'd7,      20'd34,     1'b1, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd10, 20'd3,      20'hFFFFF,  1'b1, 1'b0, 20'd0, 20'd0},
      // alternating bit patterns
      '{1'b1, 5'd19, 20'hAAAAA,  20'h55555,  1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd20, 20'h55555,  20'hAAAAA,  1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd3,  20'd7,      20'd0,      1'b0, 1'b0, 20'd0, 20'd0},
      '{1'b1, 5'd20, 20'd1,      20'd1,      1'b0, 1'b0, 20'd0, 20'd0}
   };

   nearest_first_tile_block #(
      .BLOCK_RADIUS (RADIUS),
      .MAX_ZOOM     (ZOOM_LIMIT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_base_valid (req_base_valid),
      .req_base_zoom  (req_base_zoom),
      .req_base_x     (req_base_x),
      .req_base_y     (req_base_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tile_zoom  (rsp_tile_zoom),
      .rsp_tile_x     (rsp_tile_x),
      .rsp_tile_y     (rsp_tile_y),
      .rsp_last_tile  (rsp_last_tile)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: timed out with %0d tiles still expected", pending_tiles.size());
         $display("nearest_first_tile_block: mismatch");
         $finish;
      end
   end

   task automatic report_fault(input string what);
      fault_count++;
      if (fault_count <= 10) begin
         $display("ERROR: %s", what);
      end
   endtask

   // Walk the block around a base tile, nearest first, and queue the tiles it
   // must produce. Rows off the grid are skipped, columns wrap.
   function automatic void predict_tiles(input logic ok, input logic [ZoomW-1:0] zoom,
                                         input logic [CoordW-1:0] bx,
                                         input logic [CoordW-1:0] by);
      map_tile_t walk[$];
      map_tile_t t;
      longint    grid;
      longint    row;
      if (!ok || zoom > ZOOM_LIMIT) begin
         empty_requests++;
         return;
      end
      grid = longint'(1) << zoom;
      for (int d = 0; d <= 2 * RADIUS * RADIUS; d++) begin
         for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
            for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
               if (dx * dx + dy * dy != d) continue;
               row = longint'(by) + dy;
               if (row < 0 || row >= grid) continue;
               t.zoom = zoom;
               t.x    = CoordW'((longint'(bx) + dx) & (grid - 1));
               t.y    = CoordW'(row);
               t.last = 1'b0;
               walk = {walk, t};
            end
         end
      end
      if (walk.size() == 0) begin
         empty_requests++;
      end else begin
         walk[walk.size() - 1].last = 1'b1;
      end
      foreach (walk[i]) pending_tiles = {pending_tiles, walk[i]};
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Queue expectations first, then check the tile, so that a tile leaving in
   // the same cycle as a request is taken still finds its entry.
   always @(posedge clock) begin
      map_tile_t want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            requests_taken++;
            if (row_typed) begin
               if (row_one_tile) begin
                  want.zoom = req_base_zoom;
                  want.x    = row_tx;
                  want.y    = row_ty;
                  want.last = 1'b1;
                  pending_tiles = {pending_tiles, want};
               end else begin
                  empty_requests++;
               end
            end else begin
               predict_tiles(req_base_valid, req_base_zoom, req_base_x, req_base_y);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_tiles.size() == 0) begin
               report_fault($sformatf("unexpected tile zoom %0d x %0h y %0h last %0b",
                                      rsp_tile_zoom, rsp_tile_x, rsp_tile_y,
                                      rsp_last_tile));
            end else begin
               want = pending_tiles.pop_front();
               if (rsp_tile_zoom !== want.zoom || rsp_tile_x !== want.x ||
                   rsp_tile_y !== want.y || rsp_last_tile !== want.last) begin
                  report_fault($sformatf(
                     "tile %0d: expected zoom %0d x %0h y %0h last %0b, got %0d %0h %0h %0b",
                     tiles_checked, want.zoom, want.x, want.y, want.last,
                     rsp_tile_zoom, rsp_tile_x, rsp_tile_y, rsp_last_tile));
               end
            end
            tiles_checked++;
         end
      end
   end

   // Receiver: runs of free flow broken by stalls of random length. On request
   // from the stimulus, hold the output for a long stretch so the base queue
   // fills and the block has to stall its input.
   initial begin
      int stall_len;
      while (reset) @(negedge clock);
      forever begin
         if (choke_req) begin
            rsp_stall <= 1'b1;
            for (int hold = 0; hold < HOLD_CYCLES; hold++) @(negedge clock);
            choke_req  = 1'b0;
            choke_done = 1'b1;
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end
      end
   end

   // Offer one request at the current falling edge, hold it until taken, then
   // idle for a random gap (none while the receiver is being held off).
   task automatic send_base(input stim_row_t r);
      int gap;
      req_valid      <= 1'b1;
      req_base_valid <= r.ok;
      req_base_zoom  <= r.zoom;
      req_base_x     <= r.x;
      req_base_y     <= r.y;
      row_typed      <= r.typed;
      row_one_tile   <= r.one_tile;
      row_tx         <= r.tx;
      row_ty         <= r.ty;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      gap = choke_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      stim_row_t r;
      longint    grid;
      int        counted;
      int        pick;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table first.
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_base(directed_rows[i]);
      end

      // Random bases: mostly valid zooms with rows near and past the grid
      // edges or at random, plus some dropped requests as noise.
      counted = 0;
      while (counted < N_RANDOM) begin
         pick       = $urandom_range(0, 99);
         r.typed    = 1'b0;
         r.one_tile = 1'b0;
         r.tx       = '0;
         r.ty       = '0;
         r.ok       = (pick >= 8);
         if (pick < 8) begin
            r.zoom = ZoomW'($urandom_range(0, 31));
         end else if (pick < 16) begin
            r.zoom = ZoomW'($urandom_range(ZOOM_LIMIT + 1, 31));
         end else begin
            r.zoom = ZoomW'($urandom_range(0, ZOOM_LIMIT));
         end
         grid = longint'(1) << r.zoom;
         r.x  = CoordW'($urandom);
         case ($urandom_range(0, 4))
            0: begin
               r.y = CoordW'($urandom_range(0, 3));
            end
            1: begin
               r.y = CoordW'(grid - 1 - $urandom_range(0, 3));
            end
            2: begin
               r.y = CoordW'(grid + $urandom_range(0, 2));
            end
            3: begin
               r.y = CoordW'(longint'($urandom) & (grid - 1));
            end
            default: begin
               r.y = CoordW'($urandom);
            end
         endcase
         send_base(r);
         if (r.ok && r.zoom <= ZOOM_LIMIT) counted++;
         if (counted == N_RANDOM / 3 && !choke_done) choke_req = 1'b1;
      end
      req_valid <= 1'b0;

      // Drain: wait for every queued tile, then watch for strays.
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (pending_tiles.size() != 0) begin
         report_fault($sformatf("%0d tiles never arrived", pending_tiles.size()));
      end

      $display("Covered %0d requests (%0d from the table), %0d of them yielding no tiles.",
               requests_taken, N_DIRECTED, empty_requests);
      $display("Checked %0d tiles with one %0d-cycle output hold; %0d faults.",
               tiles_checked, HOLD_CYCLES, fault_count);
      if (fault_count == 0) begin
         $display("nearest_first_tile_block: match");
      end else begin
         $display("nearest_first_tile_block: mismatch");
      end
      $finish;
   end

endmodule

/* nearest_first_tile_block.f */
hdl/nfb_pkg.sv
hdl/nfb_front.sv
hdl/nfb_queue.sv
hdl/nfb_walk.sv
hdl/nearest_first_tile_block.sv
hdl/nfb_checker.sv
test/nearest_first_tile_block_test.sv
